// ===== design/rcf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types, kernel table and divider constants for the RGB 3x3 filter.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 13;
  localparam int SUM_W  = 13;
  localparam int MAG_W  = SUM_W - 1;
  localparam int MUL_W  = 13;
  localparam int PRD_W  = MAG_W + MUL_W;
  localparam int SHF_W  = 5;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CH_W-1:0]  chan_t;
  typedef logic signed [3:0] coef_t;

  typedef enum logic [2:0] {
    FLT_GAUSS    = 3'd0,
    FLT_WEIGHTED = 3'd1,
    FLT_CROSS    = 3'd2,
    FLT_BOX      = 3'd3,
    FLT_EMBOSS   = 3'd4,
    FLT_RELIEF   = 3'd5
  } filter_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_FILTER = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // status of the window stage
  typedef struct packed {
    logic valid;
    logic produce;
    logic last;
  } s1_t;

  // index = column * 3 + row, column 0 left, row 0 top
  localparam coef_t KERNEL [6][9] = '{
    '{ 4'sd1,  4'sd2, 4'sd1,  4'sd2, 4'sd4, 4'sd2, 4'sd1, 4'sd2, 4'sd1},
    '{ 4'sd0,  4'sd1, 4'sd0,  4'sd1, 4'sd4, 4'sd1, 4'sd0, 4'sd1, 4'sd0},
    '{ 4'sd0,  4'sd1, 4'sd0,  4'sd1, 4'sd1, 4'sd1, 4'sd0, 4'sd1, 4'sd0},
    '{ 4'sd1,  4'sd1, 4'sd1,  4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1, 4'sd1},
    '{-4'sd2,  4'sd0, 4'sd0,  4'sd0, 4'sd1, 4'sd0, 4'sd0, 4'sd0, 4'sd2},
    '{-4'sd2, -4'sd1, 4'sd0, -4'sd1, 4'sd1, 4'sd1, 4'sd0, 4'sd1, 4'sd2}
  };

  // divide by reciprocal: q = (x * mult) >> shift, exact for x < 4096
  function automatic logic [MUL_W-1:0] div_mult(filter_t sel);
    case (sel)
      FLT_CROSS: div_mult = 13'd3277;
      FLT_BOX:   div_mult = 13'd7282;
      default:   div_mult = 13'd1;
    endcase
  endfunction

  function automatic logic [SHF_W-1:0] div_shift(filter_t sel);
    case (sel)
      FLT_GAUSS:    div_shift = 5'd4;
      FLT_WEIGHTED: div_shift = 5'd3;
      FLT_CROSS:    div_shift = 5'd14;
      FLT_BOX:      div_shift = 5'd16;
      default:      div_shift = 5'd0;
    endcase
  endfunction

endpackage

// ===== design/rcf_ram.sv =====
// ----------------------------------------------------------------------------
// rcf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rcf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/rcf_window.sv =====
// ----------------------------------------------------------------------------
// rcf_window
// Stream position, two line stores and the 3x3 window that feeds the lanes.
// ----------------------------------------------------------------------------
module rcf_window #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [WW-1:0]  width_eff,
  input  logic [RW-1:0]  height_eff,
  input  logic           restart,
  input  logic           in_fire,
  input  logic           kind,
  input  rcf_pkg::pix_t  pixel,
  input  logic           s1_pop,
  output rcf_pkg::s1_t   s1,
  output rcf_pkg::pix_t  taps [9]
);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] col_inc;
  logic          in_frame, take, produce, last;

  logic          s1_valid_r, s1_produce_r, s1_last_r;
  logic          s1_m_old_r, s1_m_new_r, s1_czero_r, s1_fwd_r;
  logic [CW-1:0] s1_addr_r;
  rcf_pkg::pix_t s1_px_r, s1_fwd_old_r, s1_fwd_new_r;

  rcf_pkg::pix_t older_q, newer_q, older_eff, newer_eff;
  rcf_pkg::pix_t newcol [3];
  rcf_pkg::pix_t win_r [6];
  logic          retire;

  assign in_frame = row_r < height_eff;
  assign take     = in_fire && !(kind && in_frame);
  assign produce  = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (col_r != '0));
  assign last     = (row_r == height_eff + RW'(1)) && (col_r == '0);
  assign col_inc  = WW'(col_r) + WW'(1);
  assign retire   = s1_valid_r && s1_pop;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_inc >= width_eff) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (retire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // stage 1 payload; a write still pending at the read address is forwarded
  always_ff @(posedge clk) begin
    if (take) begin
      s1_produce_r <= produce;
      s1_last_r    <= last;
      s1_m_old_r   <= row_r >= RW'(2);
      s1_m_new_r   <= row_r >= RW'(1);
      s1_czero_r   <= col_r == '0;
      s1_addr_r    <= col_r;
      s1_px_r      <= in_frame ? pixel : '0;
      s1_fwd_r     <= s1_valid_r && (s1_addr_r == col_r);
      s1_fwd_old_r <= newer_eff;
      s1_fwd_new_r <= s1_px_r;
    end
  end

  rcf_ram #(.WIDTH(rcf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (retire),
    .wr_addr (s1_addr_r),
    .wr_data (newer_eff),
    .rd_en   (take),
    .rd_addr (col_r),
    .rd_data (older_q)
  );

  rcf_ram #(.WIDTH(rcf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk     (clk),
    .wr_en   (retire),
    .wr_addr (s1_addr_r),
    .wr_data (s1_px_r),
    .rd_en   (take),
    .rd_addr (col_r),
    .rd_data (newer_q)
  );

  assign older_eff = s1_fwd_r ? s1_fwd_old_r : older_q;
  assign newer_eff = s1_fwd_r ? s1_fwd_new_r : newer_q;

  // rows above the frame read as zero
  assign newcol[0] = s1_m_old_r ? older_eff : '0;
  assign newcol[1] = s1_m_new_r ? newer_eff : '0;
  assign newcol[2] = s1_px_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      taps[k]     = win_r[k];
      taps[3 + k] = win_r[3 + k];
      taps[6 + k] = s1_czero_r ? '0 : newcol[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int k = 0; k < 6; k++) begin
        win_r[k] <= '0;
      end
    end else if (retire) begin
      for (int k = 0; k < 3; k++) begin
        if (s1_last_r) begin
          win_r[k]     <= '0;
          win_r[3 + k] <= '0;
        end else begin
          win_r[k]     <= s1_czero_r ? '0 : win_r[3 + k];
          win_r[3 + k] <= newcol[k];
        end
      end
    end
  end

  // valid, produce, last
  assign s1 = {s1_valid_r, s1_produce_r, s1_last_r};

endmodule

// ===== design/rcf_lane.sv =====
// ----------------------------------------------------------------------------
// rcf_lane
// One color channel: registered kernel sum, then divide and clamp to 0..255.
// ----------------------------------------------------------------------------
module rcf_lane (
  input  logic              clk,
  input  logic              load,
  input  rcf_pkg::filter_t  sel,
  input  rcf_pkg::chan_t    taps [9],
  output rcf_pkg::chan_t    result
);

  logic signed [rcf_pkg::SUM_W-1:0] sum_nxt, sum_r;
  logic signed [rcf_pkg::SUM_W-1:0] coef_ext [9];
  logic signed [rcf_pkg::SUM_W-1:0] pix_ext [9];
  rcf_pkg::filter_t                 sel_r;
  logic [rcf_pkg::MAG_W-1:0]        mag;
  logic [rcf_pkg::PRD_W-1:0]        prod, quo;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      coef_ext[i] = rcf_pkg::SUM_W'(rcf_pkg::KERNEL[sel][i]);
      pix_ext[i]  = rcf_pkg::SUM_W'({1'b0, taps[i]});
      sum_nxt     = sum_nxt + coef_ext[i] * pix_ext[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
      sel_r <= sel;
    end
  end

  // negative sums clamp to zero, so only the magnitude of a positive sum matters
  assign mag  = sum_r[rcf_pkg::MAG_W-1:0];
  assign prod = rcf_pkg::PRD_W'(mag) * rcf_pkg::PRD_W'(rcf_pkg::div_mult(sel_r));
  assign quo  = prod >> rcf_pkg::div_shift(sel_r);

  always_comb begin
    if (sum_r[rcf_pkg::SUM_W-1]) begin
      result = '0;
    end else if (quo > rcf_pkg::PRD_W'(255)) begin
      result = 8'hFF;
    end else begin
      result = quo[rcf_pkg::CH_W-1:0];
    end
  end

endmodule

// ===== design/rgb_convolution_3x3_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_filter
// 3x3 convolution over an RGB raster stream, one lane per color channel.
// ----------------------------------------------------------------------------
// Channel   Ports                       Contents
// input     in_tvalid/in_tready         tdata: red, green, blue; tuser: kind
// result    out_tvalid/out_tready       tdata: red, green, blue; tlast: frame end
// config    cfg_we/cfg_addr/cfg_wdata   0 filter, 1 width, 2 height
//
// One item per clock unless the output stalls; the window stage and both line
// stores take one read and one write per cycle. A result passes the window
// stage, sum stage and output register, W+1 items behind the input. Reset is
// synchronous, active low. Line stores need no clearing pass after reset. A
// stalled output holds its result while up to two more results queue behind it.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // red_in, green_in, blue_in
  input  logic                        in_tuser,   // kind
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // red_out, green_out, blue_out
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic [rcf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [rcf_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [2:0]       flt_r;
  logic [10:0]      img_w_r;
  logic [12:0]      img_h_r;
  logic [WW-1:0]    width_eff;
  logic [RW-1:0]    height_eff;
  logic             restart;
  rcf_pkg::filter_t sel_eff;

  rcf_pkg::s1_t     s1;
  rcf_pkg::pix_t    taps [9];
  rcf_pkg::pix_t    pixel;
  rcf_pkg::chan_t   ch_taps [3][9];
  rcf_pkg::chan_t   res [3];

  logic             in_fire, o_free, s2_room, s1_pop, s2_load;
  logic             s2_valid_r, s2_last_r;
  logic             out_valid_r, out_last_r;
  logic [23:0]      out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flt_r   <= rcf_pkg::FLT_GAUSS;
      img_w_r <= 11'd640;
      img_h_r <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_addr)
        rcf_pkg::REG_FILTER: flt_r   <= cfg_wdata[2:0];
        rcf_pkg::REG_WIDTH:  img_w_r <= cfg_wdata[10:0];
        rcf_pkg::REG_HEIGHT: img_h_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && ((cfg_addr == rcf_pkg::REG_WIDTH) ||
                              (cfg_addr == rcf_pkg::REG_HEIGHT));
  assign sel_eff = (flt_r inside {[3'd0:3'd5]}) ? rcf_pkg::filter_t'(flt_r)
                                                : rcf_pkg::FLT_GAUSS;

  always_comb begin
    if (img_w_r == '0) begin
      width_eff = WW'(1);
    end else if (32'(img_w_r) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(img_w_r);
    end
    if (img_h_r == '0) begin
      height_eff = RW'(1);
    end else if (32'(img_h_r) > 32'(MAX_HEIGHT)) begin
      height_eff = RW'(MAX_HEIGHT);
    end else begin
      height_eff = RW'(img_h_r);
    end
  end

  // pipeline flow: window stage -> sum stage -> output register
  assign o_free    = !out_valid_r || out_tready;
  assign s2_room   = !s2_valid_r || o_free;
  assign s1_pop    = s1.valid && (!s1.produce || s2_room);
  assign s2_load   = s1_pop && s1.produce;
  assign in_tready = !s1.valid || s1_pop;
  assign in_fire   = in_tvalid && in_tready;
  assign pixel     = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};

  rcf_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .restart    (restart),
    .in_fire    (in_fire),
    .kind       (in_tuser),
    .pixel      (pixel),
    .s1_pop     (s1_pop),
    .s1         (s1),
    .taps       (taps)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    always_comb begin
      for (int i = 0; i < 9; i++) begin
        ch_taps[g][i] = taps[i][rcf_pkg::PIX_W - 1 - rcf_pkg::CH_W * g -: rcf_pkg::CH_W];
      end
    end

    rcf_lane u_lane (
      .clk    (clk),
      .load   (s2_load),
      .sel    (sel_eff),
      .taps   (ch_taps[g]),
      .result (res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (o_free) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_valid_r && o_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // merge the three lanes into one result item
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_last_r <= s1.last;
    end
    if (s2_valid_r && o_free) begin
      out_data_r <= {res[2], res[1], res[0]};
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/rcf_check.sv =====
// ----------------------------------------------------------------------------
// rcf_check
// Port-level checks for the RGB 3x3 filter, bound to the top level.
// ----------------------------------------------------------------------------
module rcf_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // with no result waiting the pipeline always has room for an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind rgb_convolution_3x3_filter rcf_check u_rcf_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
